### rtl/core/qo_pkg.sv
package qo_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned SCALE_W         = 24;
  localparam int unsigned MS_W            = 16;
  localparam int unsigned RATE_W          = 32;
  localparam int unsigned ACC_W           = 48;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  // operation codes
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_UPDATE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // register indexes
  localparam logic [1:0] CFG_LEFT_SCALE  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_SCALE = 2'd1;
  localparam logic [1:0] CFG_TURN_SCALE  = 2'd2;

  // which product is being worked on
  typedef enum logic [1:0] {
    SEL_LEFT  = 2'd0,
    SEL_RIGHT = 2'd1,
    SEL_TURN  = 2'd2
  } rate_sel_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic            left_chan_a;
    logic            left_chan_b;
    logic            right_chan_a;
    logic            right_chan_b;
    logic [MS_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] left_vel;
    logic signed [RATE_W-1:0] right_vel;
    logic signed [RATE_W-1:0] mean_speed;
    logic signed [RATE_W-1:0] turn_rate;
    logic signed [ACC_W-1:0]  total_distance;
    logic signed [ACC_W-1:0]  total_rotation;
  } out_item_t;

  typedef struct packed {
    logic      sample;
    logic      clear;
    logic      snap;
    logic      mul;
    logic      prep;
    logic      div_step;
    logic      store;
    logic      emit;
    rate_sel_e sel;
  } qo_cmd_t;

  typedef struct packed {
    logic out_free;
  } qo_stat_t;

endpackage

### rtl/core/qo_stream_if.sv
interface qo_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/qo_ctrl.sv
module qo_ctrl
  import qo_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  output logic       in_ready_o,
  input  qo_stat_t   stat_i,
  output qo_cmd_t    cmd_o
);

  // dividend bits: |product| plus the x1000 growth
  localparam int unsigned NW     = COUNT_WIDTH + SCALE_W + 10;
  localparam int unsigned STEP_W = $clog2(NW);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_DIV,
    S_STORE,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  rate_sel_e         sel_q, sel_d;
  logic [STEP_W-1:0] step_q, step_d;
  op_e               op;

  assign op         = op_e'(in_op_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op)
            OP_SAMPLE: cmd_o.sample = 1'b1;
            OP_CLEAR:  cmd_o.clear  = 1'b1;
            OP_UPDATE: begin
              cmd_o.snap = 1'b1;
              sel_d      = SEL_LEFT;
              state_d    = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = LAST_STEP;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q - 1'b1;
        if (step_q == '0) state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        unique case (sel_q)
          SEL_LEFT: begin
            sel_d   = SEL_RIGHT;
            state_d = S_MUL;
          end
          SEL_RIGHT: begin
            sel_d   = SEL_TURN;
            state_d = S_MUL;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= SEL_LEFT;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      step_q  <= step_d;
    end
  end

endmodule

### rtl/core/qo_datapath.sv
module qo_datapath
  import qo_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [SCALE_W-1:0] cfg_data_i,
  input  in_item_t           in_data_i,
  input  qo_cmd_t            cmd_i,
  output qo_stat_t           stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned PW = CW + SCALE_W + 1;  // signed product
  localparam int unsigned MW = CW + SCALE_W;      // product magnitude
  localparam int unsigned NW = MW + 10;           // magnitude * 1000
  localparam int unsigned SW = ((PW > ACC_W) ? PW : ACC_W) + 1;

  localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] ACC_MAX_X = {{(SW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN_X = {{(SW-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
  localparam logic [RATE_W:0] LIM_POS = {2'b00, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W:0] LIM_NEG = {2'b01, {(RATE_W-1){1'b0}}};

  function automatic logic [CW-1:0] step_cnt(input logic [CW-1:0] c, input logic up);
    logic [CW-1:0] r;
    if (up) r = (c == CNT_MAX) ? c : c + 1'b1;
    else    r = (c == CNT_MIN) ? c : c - 1'b1;
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] acc_sat(input logic [ACC_W-1:0] acc,
                                               input logic [PW-1:0] inc);
    logic signed [SW-1:0] s;
    s = $signed({{(SW-ACC_W){acc[ACC_W-1]}}, acc}) + $signed({{(SW-PW){inc[PW-1]}}, inc});
    if (s > ACC_MAX_X)      s = ACC_MAX_X;
    else if (s < ACC_MIN_X) s = ACC_MIN_X;
    return s[ACC_W-1:0];
  endfunction

  // config and odometry state
  logic [SCALE_W-1:0] scale_l_q, scale_r_q, scale_t_q;
  logic               prev_la_q, prev_ra_q;
  logic [CW-1:0]      cnt_l_q, cnt_r_q;
  logic [ACC_W-1:0]   dist_q, rot_q;

  // working registers
  logic [CW-1:0]      snap_l_q, snap_r_q;
  logic [MS_W-1:0]    ms_q;
  logic [PW-1:0]      prod_q;
  logic               neg_q;
  logic [NW-1:0]      num_q;
  logic [MS_W-1:0]    rem_q;
  logic [RATE_W:0]    quot_q;
  logic               ovf_q;
  logic [RATE_W-1:0]  rate_l_q, rate_r_q, rate_t_q;
  out_item_t          out_q;
  logic               out_valid_q;

  // multiplier operands
  logic signed [CW:0]           mul_a;
  logic signed [SCALE_W:0]      mul_b;
  logic signed [CW+SCALE_W+1:0] mul_full;

  always_comb begin
    case (cmd_i.sel)
      SEL_LEFT: begin
        mul_a = $signed({snap_l_q[CW-1], snap_l_q});
        mul_b = $signed({1'b0, scale_l_q});
      end
      SEL_RIGHT: begin
        mul_a = $signed({snap_r_q[CW-1], snap_r_q});
        mul_b = $signed({1'b0, scale_r_q});
      end
      default: begin
        mul_a = $signed({snap_l_q[CW-1], snap_l_q}) - $signed({snap_r_q[CW-1], snap_r_q});
        mul_b = $signed({1'b0, scale_t_q});
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // magnitude, then x1000 as shifts
  logic [PW-1:0] mag_full;
  logic [NW-1:0] mag_ext, num_d;
  assign mag_full = prod_q[PW-1] ? (~prod_q + 1'b1) : prod_q;
  assign mag_ext  = {10'd0, mag_full[MW-1:0]};
  assign num_d    = (mag_ext << 10) - (mag_ext << 4) - (mag_ext << 3);

  // restoring divide, one quotient bit per cycle
  logic [MS_W:0] trial, diff;
  logic          ge;
  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, ms_q};
  assign ge    = (trial >= {1'b0, ms_q});

  // saturate and sign the quotient
  logic [RATE_W:0]   lim, v, v_neg;
  logic [RATE_W-1:0] rate_val;
  assign lim      = neg_q ? LIM_NEG : LIM_POS;
  assign v        = (ovf_q || (quot_q > lim)) ? lim : quot_q;
  assign v_neg    = ~v + 1'b1;
  assign rate_val = neg_q ? v_neg[RATE_W-1:0] : v[RATE_W-1:0];

  logic signed [RATE_W:0] sum;
  assign sum = $signed({rate_l_q[RATE_W-1], rate_l_q}) + $signed({rate_r_q[RATE_W-1], rate_r_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_l_q   <= SCALE_RESET;
      scale_r_q   <= SCALE_RESET;
      scale_t_q   <= SCALE_RESET;
      prev_la_q   <= 1'b0;
      prev_ra_q   <= 1'b0;
      cnt_l_q     <= '0;
      cnt_r_q     <= '0;
      dist_q      <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEFT_SCALE:  scale_l_q <= cfg_data_i;
          CFG_RIGHT_SCALE: scale_r_q <= cfg_data_i;
          CFG_TURN_SCALE:  scale_t_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.sample) begin
        if (in_data_i.left_chan_a != prev_la_q)
          cnt_l_q <= step_cnt(cnt_l_q, in_data_i.left_chan_a == in_data_i.left_chan_b);
        if (in_data_i.right_chan_a != prev_ra_q)
          cnt_r_q <= step_cnt(cnt_r_q, in_data_i.right_chan_a != in_data_i.right_chan_b);
        prev_la_q <= in_data_i.left_chan_a;
        prev_ra_q <= in_data_i.right_chan_a;
      end
      if (cmd_i.clear || cmd_i.snap) begin
        cnt_l_q <= '0;
        cnt_r_q <= '0;
      end
      if (cmd_i.prep) begin
        if (cmd_i.sel == SEL_LEFT) dist_q <= acc_sat(dist_q, prod_q);
        if (cmd_i.sel == SEL_TURN) rot_q  <= acc_sat(rot_q, prod_q);
      end
      if (cmd_i.emit)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      snap_l_q <= cnt_l_q;
      snap_r_q <= cnt_r_q;
      ms_q     <= (in_data_i.elapsed_ms == '0) ? MS_W'(1) : in_data_i.elapsed_ms;
    end
    if (cmd_i.mul) prod_q <= mul_full[PW-1:0];
    if (cmd_i.prep) begin
      neg_q  <= prod_q[PW-1];
      num_q  <= num_d;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end
    if (cmd_i.div_step) begin
      num_q  <= num_q << 1;
      rem_q  <= ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
      quot_q <= {quot_q[RATE_W-1:0], ge};
      ovf_q  <= ovf_q | quot_q[RATE_W];
    end
    if (cmd_i.store) begin
      case (cmd_i.sel)
        SEL_LEFT:  rate_l_q <= rate_val;
        SEL_RIGHT: rate_r_q <= rate_val;
        default:   rate_t_q <= rate_val;
      endcase
    end
    if (cmd_i.emit) begin
      out_q.left_vel       <= rate_l_q;
      out_q.right_vel      <= rate_r_q;
      out_q.mean_speed     <= sum[RATE_W:1];
      out_q.turn_rate      <= rate_t_q;
      out_q.total_distance <= dist_q;
      out_q.total_rotation <= rot_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

### rtl/core/quadrature_odometry.sv
// Channel   Dir  Beat payload                                Handshake
// in_if     in   operation, four pin levels, elapsed_ms      valid/ready
// out_if    out  three speeds, turn rate, two totals         valid/ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (24 bit)    write enable, no wait
//
// Sample and clear beats leave ready high, so pin samples can come back to back.
// An update beat holds ready low while the bit-serial divider, one bit per cycle, runs
// three times, plus any wait for the output register.
// Reset zeroes counts and accumulators and sets every scale to 1.0; no clearing pass.
// A result held in the output register blocks nothing until the next update is ready
// to emit; that update then waits there with ready low.
module quadrature_odometry
  import qo_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [SCALE_W-1:0] cfg_data_i,
  qo_stream_if.sink          in_if,
  qo_stream_if.source        out_if
);

  qo_cmd_t  cmd;
  qo_stat_t stat;
  in_item_t in_data;
  out_item_t out_data;

  assign in_data = in_if.data;

  // sequencer: accepts beats when idle, steps the rate pipeline for updates
  qo_ctrl #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_op_i    (in_data.operation),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // counters, multiplier, divider, accumulators and the output register
  qo_datapath #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_data)
  );

  assign out_if.data = out_data;

endmodule

### test/tb_quadrature_odometry.sv
`timescale 1ns / 1ps

module tb_quadrature_odometry
  import qo_pkg::*;
();

  // Register index that maps to no scale; writes to it must change nothing.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Window count limits for the default counter width.
  localparam int CNT_HI = (1 << (COUNT_WIDTH_DEF - 1)) - 1;
  localparam int CNT_LO = -(1 << (COUNT_WIDTH_DEF - 1));

  // Accumulator limits, signed 48 bit.
  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< (ACC_W - 1));

  // ---------------------------------------------------------------------------
  // Odometry tracker: mirrors the block's counts, scales and totals, and holds
  // the readings each accepted update beat should produce, oldest first.
  // ---------------------------------------------------------------------------
  class odometry_tracker;
    longint    left_scale;
    longint    right_scale;
    longint    turn_scale;
    logic      left_prev_a;
    logic      right_prev_a;
    int        left_count;
    int        right_count;
    longint    distance;
    longint    rotation;
    out_item_t expected_readings[$];
    int        errors;

    function new();
      left_scale   = SCALE_RESET;
      right_scale  = SCALE_RESET;
      turn_scale   = SCALE_RESET;
      left_prev_a  = 1'b0;
      right_prev_a = 1'b0;
      left_count   = 0;
      right_count  = 0;
      distance     = 0;
      rotation     = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [SCALE_W-1:0] val);
      case (idx)
        CFG_LEFT_SCALE:  left_scale  = val;
        CFG_RIGHT_SCALE: right_scale = val;
        CFG_TURN_SCALE:  turn_scale  = val;
        default: ;
      endcase
    endfunction

    static function int bump(int c, bit up);
      if (up) return (c < CNT_HI) ? c + 1 : CNT_HI;
      return (c > CNT_LO) ? c - 1 : CNT_LO;
    endfunction

    // prod * 1000 / ms, magnitude truncated, clamped to signed 32 bit
    static function longint per_second(longint prod, longint unsigned ms);
      bit              neg;
      longint unsigned mag;
      longint unsigned lim;
      longint unsigned quo;
      longint unsigned rem;
      longint unsigned v;
      neg = prod < 0;
      mag = neg ? -prod : prod;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      quo = mag / ms;
      rem = mag % ms;
      if (quo >= 64'h1_0000_0000) v = lim;
      else v = quo * 64'd1000 + (rem * 64'd1000) / ms;
      if (v > lim) v = lim;
      return neg ? -longint'(v) : longint'(v);
    endfunction

    static function longint acc_clamp(longint acc, longint inc);
      longint s;
      s = acc + inc;
      if (s > ACC_HI) return ACC_HI;
      if (s < ACC_LO) return ACC_LO;
      return s;
    endfunction

    function void take_beat(in_item_t beat);
      longint          pl;
      longint          pr;
      longint          pd;
      longint          ls;
      longint          rs;
      longint          tr;
      longint          sum;
      longint unsigned ms;
      out_item_t       r;
      case (beat.operation)
        OP_SAMPLE: begin
          if (beat.left_chan_a != left_prev_a)
            left_count = bump(left_count, beat.left_chan_a == beat.left_chan_b);
          // right wheel is mounted mirrored
          if (beat.right_chan_a != right_prev_a)
            right_count = bump(right_count, beat.right_chan_a != beat.right_chan_b);
          left_prev_a  = beat.left_chan_a;
          right_prev_a = beat.right_chan_a;
        end
        OP_CLEAR: begin
          left_count  = 0;
          right_count = 0;
        end
        OP_UPDATE: begin
          pl = longint'(left_count) * left_scale;
          pr = longint'(right_count) * right_scale;
          pd = longint'(left_count - right_count) * turn_scale;
          left_count  = 0;
          right_count = 0;
          ms  = (beat.elapsed_ms == '0) ? 64'd1 : beat.elapsed_ms;
          ls  = per_second(pl, ms);
          rs  = per_second(pr, ms);
          tr  = per_second(pd, ms);
          sum = ls + rs;
          distance = acc_clamp(distance, pl);
          rotation = acc_clamp(rotation, pd);
          r.left_vel       = RATE_W'(ls);
          r.right_vel      = RATE_W'(rs);
          r.mean_speed     = RATE_W'(sum >>> 1);  // floor of the mean
          r.turn_rate      = RATE_W'(tr);
          r.total_distance = ACC_W'(distance);
          r.total_rotation = ACC_W'(rotation);
          expected_readings.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reading(out_item_t got);
      out_item_t want;
      if (expected_readings.size() == 0) begin
        $error("reading arrived with no update pending");
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      compare("left_vel",       want.left_vel,       got.left_vel);
      compare("right_vel",      want.right_vel,      got.right_vel);
      compare("mean_speed",     want.mean_speed,     got.mean_speed);
      compare("turn_rate",      want.turn_rate,      got.turn_rate);
      compare("total_distance", want.total_distance, got.total_distance);
      compare("total_rotation", want.total_rotation, got.total_rotation);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, block
  // ---------------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  logic [SCALE_W-1:0] cfg_data;

  qo_stream_if #(.T(in_item_t))  in_if ();
  qo_stream_if #(.T(out_item_t)) out_if ();

  quadrature_odometry dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  odometry_tracker tracker = new();

  bit   calm;        // when set, neither side idles
  logic pin_la;      // last A levels sampled, to build real quadrature steps
  logic pin_ra;
  int   beats_sent;  // beats that reach the block's logic (op 3 not counted)

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: worst case is well under 5 ms even with every gap at its longest.
  initial begin
    #(20ms);
    $display("** quadrature_odometry: FAILED **");
    $finish;
  end

  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  // Elapsed time: mostly short windows, with zero, one and the top value mixed in.
  function automatic logic [MS_W-1:0] draw_ms();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return MS_W'(1);
      3:       return MS_W'($urandom_range(0, 65535));
      default: return MS_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] draw_scale();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SCALE_RESET;
      default: return SCALE_W'($urandom());
    endcase
  endfunction

  function automatic int pick_dir();
    return int'($urandom_range(0, 2)) - 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Each call starts just after a rising edge; valid stays high
  // across back-to-back beats and drops only when a gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_beat(in_item_t beat);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= beat;
    do @(posedge clk); while (!in_if.ready);
    tracker.take_beat(beat);
    if (beat.operation != OP_NONE) beats_sent++;
  endtask

  task automatic sample_pins(logic la, logic lb, logic ra, logic rb);
    in_item_t b;
    b.operation    = OP_SAMPLE;
    b.left_chan_a  = la;
    b.left_chan_b  = lb;
    b.right_chan_a = ra;
    b.right_chan_b = rb;
    b.elapsed_ms   = MS_W'($urandom());  // ignored on samples, but keep it busy
    send_beat(b);
    pin_la = la;
    pin_ra = ra;
  endtask

  // One quadrature step per wheel: +1 counts up, -1 down, 0 holds A still.
  task automatic move_wheels(int ldir, int rdir);
    logic la;
    logic lb;
    logic ra;
    logic rb;
    la = (ldir != 0) ? ~pin_la : pin_la;
    if (ldir > 0) lb = la;
    else if (ldir < 0) lb = ~la;
    else lb = 1'($urandom_range(0, 1));
    ra = (rdir != 0) ? ~pin_ra : pin_ra;
    if (rdir > 0) rb = ~ra;  // right wheel counts mirrored
    else if (rdir < 0) rb = ra;
    else rb = 1'($urandom_range(0, 1));
    sample_pins(la, lb, ra, rb);
  endtask

  task automatic send_op(op_e op, logic [MS_W-1:0] ms);
    in_item_t b;
    b.operation    = op;
    b.left_chan_a  = 1'($urandom_range(0, 1));
    b.left_chan_b  = 1'($urandom_range(0, 1));
    b.right_chan_a = 1'($urandom_range(0, 1));
    b.right_chan_b = 1'($urandom_range(0, 1));
    b.elapsed_ms   = ms;
    send_beat(b);
  endtask

  // Drain: hold the input, let every reading come out, then cover any
  // sample or clear still in flight before touching the scales.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [SCALE_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // Writes back to back; write enable drops once, after the last one.
  task automatic set_scales(logic [SCALE_W-1:0] l, logic [SCALE_W-1:0] r,
                            logic [SCALE_W-1:0] t, bit stray);
    write_cfg(CFG_LEFT_SCALE, l);
    write_cfg(CFG_RIGHT_SCALE, r);
    write_cfg(CFG_TURN_SCALE, t);
    if (stray) write_cfg(CFG_UNUSED, SCALE_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stalls either up front or by sitting on a waiting reading.
  // ---------------------------------------------------------------------------
  initial begin : drain
    int stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait();
      if (stall == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        do @(posedge clk); while (!out_if.valid);
        repeat (stall - 1) @(posedge clk);
        out_if.ready <= 1'b1;
      end
      do @(posedge clk); while (!out_if.valid);
      tracker.check_reading(out_if.data);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    int ldir;
    int rdir;
    int mark;
    int start_beats;
    int updates;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_LEFT_SCALE;
    cfg_data    <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    calm        = 1'b0;
    pin_la      = 1'b0;
    pin_ra      = 1'b0;
    beats_sent  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset scales ---
    send_op(OP_UPDATE, '0);           // nothing counted, zero elapsed time
    repeat (3) move_wheels(1, 1);
    send_op(OP_UPDATE, MS_W'(1));
    repeat (2) move_wheels(-1, -1);
    send_op(OP_NONE, '1);             // unused op: no reading, pins not latched
    send_op(OP_UPDATE, '1);           // longest window
    repeat (2) move_wheels(1, -1);
    send_op(OP_CLEAR, MS_W'(9));      // wipes the window before the update
    send_op(OP_UPDATE, MS_W'(7));

    // --- top scales: every rate clamps, both signs ---
    settle();
    set_scales('1, '1, '1, 1'b1);
    repeat (3) move_wheels(1, -1);
    send_op(OP_UPDATE, MS_W'(1));
    repeat (2) move_wheels(-1, 1);
    send_op(OP_UPDATE, '0);

    // --- zero scales, then pin extremes ---
    settle();
    set_scales('0, '0, '0, 1'b0);
    move_wheels(1, 1);
    send_op(OP_UPDATE, MS_W'(3));
    sample_pins(1'b1, 1'b1, 1'b1, 1'b1);
    sample_pins(1'b0, 1'b0, 1'b0, 1'b0);
    send_op(OP_UPDATE, MS_W'(2));

    // --- random: mostly clean motion bursts closed by an update ---
    start_beats = beats_sent;
    updates     = 0;
    mark        = 0;
    while (beats_sent - start_beats < 420 || updates < 40) begin
      if (beats_sent - start_beats >= mark) begin
        settle();
        set_scales(draw_scale(), draw_scale(), draw_scale(), 1'($urandom_range(0, 1)));
        mark += 110;
      end
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        7, 8: begin  // noise: arbitrary pin levels
          n = $urandom_range(1, 6);
          repeat (n) sample_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        9: begin
          if ($urandom_range(0, 1)) send_op(OP_CLEAR, MS_W'($urandom()));
          else send_op(OP_NONE, MS_W'($urandom()));
        end
        default: begin
          n    = $urandom_range(1, 16);
          ldir = pick_dir();
          rdir = pick_dir();
          repeat (n) begin
            if ($urandom_range(0, 7) == 0) ldir = pick_dir();  // wheel reverses
            if ($urandom_range(0, 7) == 0) rdir = pick_dir();
            move_wheels(ldir, rdir);
          end
          if ($urandom_range(0, 9) == 0) send_op(OP_CLEAR, MS_W'($urandom()));
          send_op(OP_UPDATE, draw_ms());
          updates++;
        end
      endcase
      // now and then hold off until every reading is back
      if ($urandom_range(0, 14) == 0) settle();
    end

    // --- wind down: all readings back, then a quiet stretch for strays ---
    calm = 1'b0;
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d readings never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("** quadrature_odometry: PASSED **");
    end else begin
      $display("** quadrature_odometry: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/qo_pkg.sv
rtl/core/qo_stream_if.sv
rtl/core/qo_ctrl.sv
rtl/core/qo_datapath.sv
rtl/core/quadrature_odometry.sv
test/tb_quadrature_odometry.sv
